FILE: src/ldr_pkg.sv
// Package: shared types and constants for the line and disc rasterizer.
package ldr_pkg;

	localparam int CoordBits  = 12;
	localparam int RadiusBits = 8;
	localparam int PaintBits  = 16;
	localparam int CurBits    = CoordBits + 2;
	localparam int ErrBits    = 2 * CoordBits + 4;
	localparam int QDepth     = 2;

	typedef enum logic [1:0] {
		CMD_LINE = 2'd0,
		CMD_DISC = 2'd1,
		CMD_STEP = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]            command;
		logic [CoordBits-1:0]  first_x;
		logic [CoordBits-1:0]  first_y;
		logic [CoordBits-1:0]  second_x;
		logic [CoordBits-1:0]  second_y;
		logic [RadiusBits-1:0] disc_size;
		logic [PaintBits-1:0]  paint;
	} req_t;

	typedef struct packed {
		logic                  pixel_valid;
		logic [CoordBits-1:0]  pixel_x;
		logic [CoordBits-1:0]  pixel_y;
		logic [PaintBits-1:0]  pixel_paint;
		logic                  final_pixel;
	} pix_t;

endpackage

FILE: src/ldr_if.sv
// Interface: valid/ready channel carrying one payload.
interface ldr_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/ldr_front.sv
// Front: accepts requests, drops ignored commands, queues the rest.
module ldr_front (
	input  logic  clk,
	input  logic  arst_n,
	ldr_if.sink   in_ch,
	output logic  q_valid,
	output ldr_pkg::req_t q_data,
	input  logic  q_pop
);
	ldr_pkg::req_t mem_q [ldr_pkg::QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready &&
		(in_ch.data.command != ldr_pkg::CMD_NONE);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rp_q];

	// two-entry request queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_ch.data;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push || q_pop) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != 2'd0) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
`endif
endmodule

FILE: src/ldr_back.sv
// Back: walks lines and discs, one pixel per step request.
module ldr_back (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  ldr_pkg::req_t q_data,
	output logic  q_pop,
	ldr_if.source out_ch
);
	localparam int CB = ldr_pkg::CoordBits;
	localparam int WB = ldr_pkg::CurBits;
	localparam int EB = ldr_pkg::ErrBits;
	localparam int RB = ldr_pkg::RadiusBits;
	localparam int SB = 2 * (CB + 2) + 2;

	typedef enum logic [1:0] {M_IDLE, M_LINE, M_DISC} mode_t;

	mode_t mode_q;
	logic signed [WB-1:0] cx_q, cy_q;
	logic [CB-1:0] tx_q, ty_q, ox_q, oy_q;
	logic [RB-1:0] r_q;
	logic [ldr_pkg::PaintBits-1:0] paint_q;
	logic signed [EB-1:0] err_q, dx_q, dy_q;
	logic signed [WB-1:0] ofx_s1, ofy_s1;
	logic [2*RB-1:0] rr_q;
	logic ovld_q;
	ldr_pkg::pix_t opix_q;

	logic take, do_step;
	logic signed [EB-1:0] e_r, e_v, ar, av, dxs;
	logic signed [WB-1:0] ctx, cty, lim_x, lim_y, s_w, ofx, ofy;
	logic signed [2*WB-1:0] sq_x, sq_y;
	logic [SB-1:0] dsq;
	logic in_disc, onc;
	ldr_pkg::pix_t pix;

	assign out_ch.valid = ovld_q;
	assign out_ch.data = opix_q;
	assign take = q_valid && (!ovld_q || out_ch.ready);
	assign q_pop = take;
	assign do_step = take && (q_data.command == ldr_pkg::CMD_STEP);

	// line error terms, disc distance test and the pixel for the current position
	always_comb begin
		ctx = WB'($signed({1'b0, ox_q}));
		cty = WB'($signed({1'b0, oy_q}));
		lim_x = ctx + WB'($signed({1'b0, r_q}));
		lim_y = cty + WB'($signed({1'b0, r_q}));
		s_w = (dy_q > 0) ? WB'(1) : ((dy_q < 0) ? -WB'(1) : WB'(0));
		dxs = (dy_q > 0) ? dx_q : ((dy_q < 0) ? -dx_q : EB'(0));
		e_r = err_q + dy_q;
		e_v = err_q - dxs;
		ar = e_r[EB-1] ? -e_r : e_r;
		av = e_v[EB-1] ? -e_v : e_v;
		ofx = cx_q - ctx;
		ofy = cy_q - cty;
		// squares at full product width
		sq_x = ofx * ofx;
		sq_y = ofy * ofy;
		dsq = SB'(sq_x) + SB'(sq_y);
		in_disc = dsq <= SB'(rr_q);
		onc = !cx_q[WB-1] && !cy_q[WB-1] && (cx_q[WB-2:CB] == '0) &&
			(cy_q[WB-2:CB] == '0);
		pix = '0;
		if (mode_q == M_LINE) begin
			pix.pixel_valid = 1'b1;
			pix.pixel_x = cx_q[CB-1:0];
			pix.pixel_y = cy_q[CB-1:0];
			pix.pixel_paint = paint_q;
			pix.final_pixel = (cx_q[CB-1:0] == tx_q) && (cy_q[CB-1:0] == ty_q);
		end else if (mode_q == M_DISC) begin
			pix.pixel_paint = paint_q;
			if (in_disc && onc) begin
				pix.pixel_valid = 1'b1;
				pix.pixel_x = cx_q[CB-1:0];
				pix.pixel_y = cy_q[CB-1:0];
			end
			pix.final_pixel = (cx_q >= lim_x) && (cy_q >= lim_y);
		end
	end

	// primitive state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			ovld_q <= 1'b0;
		end else begin
			ovld_q <= do_step || (ovld_q && !out_ch.ready);
			if (take) begin
				unique case (q_data.command)
					ldr_pkg::CMD_LINE: mode_q <= M_LINE;
					ldr_pkg::CMD_DISC: mode_q <= M_DISC;
					default: begin
						if (pix.final_pixel) mode_q <= M_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		ofx_s1 <= ofx;
		ofy_s1 <= ofy;
		if (do_step) opix_q <= pix;
		if (take) begin
			unique case (q_data.command)
				ldr_pkg::CMD_LINE: begin
					if (q_data.first_x > q_data.second_x) begin
						cx_q <= WB'($signed({1'b0, q_data.second_x}));
						cy_q <= WB'($signed({1'b0, q_data.second_y}));
						tx_q <= q_data.first_x;
						ty_q <= q_data.first_y;
						dx_q <= EB'($signed({1'b0, q_data.first_x})) -
							EB'($signed({1'b0, q_data.second_x}));
						dy_q <= EB'($signed({1'b0, q_data.first_y})) -
							EB'($signed({1'b0, q_data.second_y}));
					end else begin
						cx_q <= WB'($signed({1'b0, q_data.first_x}));
						cy_q <= WB'($signed({1'b0, q_data.first_y}));
						tx_q <= q_data.second_x;
						ty_q <= q_data.second_y;
						dx_q <= EB'($signed({1'b0, q_data.second_x})) -
							EB'($signed({1'b0, q_data.first_x}));
						dy_q <= EB'($signed({1'b0, q_data.second_y})) -
							EB'($signed({1'b0, q_data.first_y}));
					end
					err_q <= '0;
					paint_q <= q_data.paint;
				end
				ldr_pkg::CMD_DISC: begin
					ox_q <= q_data.first_x;
					oy_q <= q_data.first_y;
					r_q <= q_data.disc_size;
					rr_q <= q_data.disc_size * q_data.disc_size;
					cx_q <= WB'($signed({1'b0, q_data.first_x})) -
						WB'($signed({1'b0, q_data.disc_size}));
					cy_q <= WB'($signed({1'b0, q_data.first_y})) -
						WB'($signed({1'b0, q_data.disc_size}));
					paint_q <= q_data.paint;
				end
				default: begin
					if (mode_q == M_LINE && !pix.final_pixel) begin
						if (cx_q[CB-1:0] == tx_q) begin
							cy_q <= cy_q + s_w;
							err_q <= e_v;
						end else if (cy_q[CB-1:0] == ty_q) begin
							cx_q <= cx_q + WB'(1);
							err_q <= e_r;
						end else if (ar < av) begin
							cx_q <= cx_q + WB'(1);
							err_q <= e_r;
						end else if (ar > av) begin
							cy_q <= cy_q + s_w;
							err_q <= e_v;
						end else begin
							cx_q <= cx_q + WB'(1);
							cy_q <= cy_q + s_w;
							err_q <= e_r - dxs;
						end
					end else if (mode_q == M_DISC && !pix.final_pixel) begin
						if (cy_q + WB'(1) > lim_y) begin
							cy_q <= cty - WB'($signed({1'b0, r_q}));
							cx_q <= cx_q + WB'(1);
						end else begin
							cy_q <= cy_q + WB'(1);
						end
					end
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_step_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		do_step |=> ovld_q) else $error("step gave no result");
	a_final_idles: assert property (@(posedge clk) disable iff (!arst_n)
		do_step && pix.final_pixel |=> mode_q == M_IDLE) else $error("no idle after final");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && !out_ch.ready |-> !take) else $error("took while stalled");
	a_offs_used: assert property (@(posedge clk) disable iff (!arst_n)
		$past(mode_q) == M_DISC && $stable(cx_q) && $stable(cy_q) && $stable(ox_q)
		&& $stable(oy_q) |-> ofx_s1 == ofx && ofy_s1 == ofy)
		else $error("offset mismatch");
`endif
endmodule

FILE: src/line_and_disc_rasterizer_core.sv
// Top level: line and disc rasterizer, front queue and pixel back end.
// A step request passes through the front queue and the back end's output register before its pixel is offered.
// Throughput: one request per cycle, and the back end retires one per cycle, while the pixel output is not stalled.
// Begin requests give no result; the two-entry queue decouples front and back.
// Reset (arst_n low, asynchronous) empties the queue and idles the walker.
module line_and_disc_rasterizer_core (
	input logic clk,
	input logic arst_n,
	ldr_if.sink   req,
	ldr_if.source pix
);
	logic q_valid, q_pop;
	ldr_pkg::req_t q_data;

	ldr_front u_front (.clk, .arst_n, .in_ch(req), .q_valid, .q_data, .q_pop);
	ldr_back u_back (.clk, .arst_n, .q_valid, .q_data, .q_pop, .out_ch(pix));
endmodule

FILE: tb/line_and_disc_rasterizer_core_test.sv
// Testbench: line and disc rasterizer core checked against an in-bench pixel predictor.
module line_and_disc_rasterizer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	ldr_if #(.payload_t(ldr_pkg::req_t)) req ();
	ldr_if #(.payload_t(ldr_pkg::pix_t)) pix ();

	line_and_disc_rasterizer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.pix(pix.source)
	);

	typedef enum int {WALK_IDLE, WALK_LINE, WALK_DISC} walk_t;

	// predictor state
	walk_t walk;
	int cur_x, cur_y, end_x, end_y, ctr_x, ctr_y, rad, span_x, span_y;
	logic [15:0] held_paint;
	longint err;

	ldr_pkg::pix_t pixel_queue[$];
	int fails = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_recv = 1'b0;

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Advance the predictor by one accepted request.
	task automatic predict_pixel(ldr_pkg::req_t r);
		ldr_pkg::pix_t p;
		int ax, ay, bx, by, t, s;
		longint er, ev, ox, oy;
		ax = r.first_x; ay = r.first_y; bx = r.second_x; by = r.second_y;
		p = '0;
		case (ldr_pkg::cmd_t'(r.command))
			ldr_pkg::CMD_LINE: begin
				if (ax > bx) begin
					t = ax; ax = bx; bx = t;
					t = ay; ay = by; by = t;
				end
				cur_x = ax; cur_y = ay; end_x = bx; end_y = by;
				span_x = bx - ax; span_y = by - ay;
				err = 0; held_paint = r.paint; walk = WALK_LINE;
			end
			ldr_pkg::CMD_DISC: begin
				ctr_x = ax; ctr_y = ay; rad = r.disc_size;
				cur_x = ax - rad; cur_y = ay - rad;
				held_paint = r.paint; walk = WALK_DISC;
			end
			ldr_pkg::CMD_STEP: begin
				if (walk == WALK_LINE) begin
					p.pixel_valid = 1'b1;
					p.pixel_x = cur_x[11:0];
					p.pixel_y = cur_y[11:0];
					p.pixel_paint = held_paint;
					if (cur_x == end_x && cur_y == end_y) begin
						p.final_pixel = 1'b1;
						walk = WALK_IDLE;
					end else begin
						s = span_y > 0 ? 1 : (span_y < 0 ? -1 : 0);
						er = err + span_y;
						ev = err - longint'(span_x) * s;
						if (cur_x == end_x) begin
							cur_y += s; err = ev;
						end else if (cur_y == end_y) begin
							cur_x += 1; err = er;
						end else if (absval(er) < absval(ev)) begin
							cur_x += 1; err = er;
						end else if (absval(er) > absval(ev)) begin
							cur_y += s; err = ev;
						end else begin
							cur_x += 1; cur_y += s;
							err = er - longint'(span_x) * s;
						end
					end
				end else if (walk == WALK_DISC) begin
					ox = cur_x - ctr_x;
					oy = cur_y - ctr_y;
					p.pixel_paint = held_paint;
					if (ox * ox + oy * oy <= longint'(rad) * rad && cur_x >= 0 &&
							cur_x <= 4095 && cur_y >= 0 && cur_y <= 4095) begin
						p.pixel_valid = 1'b1;
						p.pixel_x = cur_x[11:0];
						p.pixel_y = cur_y[11:0];
					end
					if (cur_x >= ctr_x + rad && cur_y >= ctr_y + rad) begin
						p.final_pixel = 1'b1;
						walk = WALK_IDLE;
					end else begin
						cur_y += 1;
						if (cur_y > ctr_y + rad) begin
							cur_y = ctr_y - rad;
							cur_x += 1;
						end
					end
				end
				pixel_queue.push_back(p);
			end
			default: ;
		endcase
	endtask

	// Drive one request and wait for its acceptance; valid stays up afterwards.
	task automatic send_request(ldr_pkg::req_t r);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		do @(posedge clk); while (!req.ready);
		predict_pixel(r);
		@(negedge clk);
	endtask

	function automatic ldr_pkg::req_t make_req(ldr_pkg::cmd_t c, int ax, int ay, int bx,
			int by, int rd, int pt);
		ldr_pkg::req_t r;
		r.command = c; r.first_x = 12'(ax); r.first_y = 12'(ay); r.second_x = 12'(bx);
		r.second_y = 12'(by); r.disc_size = 8'(rd); r.paint = 16'(pt);
		return r;
	endfunction

	task automatic step_n(int n);
		repeat (n) send_request(make_req(ldr_pkg::CMD_STEP, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom));
	endtask

	// Drop valid and wait for every expected result.
	task automatic wait_drain();
		req.valid <= 1'b0;
		@(negedge clk);
		while (pixel_queue.size() != 0) @(negedge clk);
	endtask

	// One random primitive and a random run of steps: lines, discs (small ones fully walked), or noise.
	task automatic random_primitive(output int items);
		int ax, ay, len, rd, n, pick;
		pick = $urandom_range(9, 0);
		ax = ($urandom_range(3, 0) == 0) ? ($urandom_range(1, 0) ? $urandom_range(4095, 4080)
			: $urandom_range(15, 0)) : $urandom_range(4095, 0);
		ay = ($urandom_range(3, 0) == 0) ? ($urandom_range(1, 0) ? $urandom_range(4095, 4080)
			: $urandom_range(15, 0)) : $urandom_range(4095, 0);
		items = 1;
		if (pick < 5) begin
			len = 12;
			send_request(make_req(ldr_pkg::CMD_LINE, ax, ay,
				(ax + int'($urandom_range(2 * len, 0)) - len) & 4095,
				(ay + int'($urandom_range(2 * len, 0)) - len) & 4095, $urandom, $urandom));
			n = $urandom_range(30, 1);
		end else if (pick < 8) begin
			rd = ($urandom_range(19, 0) == 0) ? $urandom_range(255, 200) : $urandom_range(4, 0);
			send_request(make_req(ldr_pkg::CMD_DISC, ax, ay, $urandom, $urandom, rd,
				$urandom));
			n = (rd > 4) ? $urandom_range(20, 1) : (2 * rd + 1) * (2 * rd + 1);
		end else if (pick == 8) begin
			send_request(make_req(ldr_pkg::CMD_NONE, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom));
			n = $urandom_range(2, 0);
		end else begin
			send_request(make_req(ldr_pkg::CMD_LINE, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom));
			n = $urandom_range(8, 1);
		end
		step_n(n);
		items += n;
	endtask

	// Receiver: random idling, or a long hold-off when asked.
	always @(negedge clk) begin
		if (!arst_n || hold_recv)
			pix.ready <= 1'b0;
		else
			pix.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
	end

	// Result checker.
	always @(posedge clk) begin
		ldr_pkg::pix_t want;
		if (arst_n && pix.valid && pix.ready) begin
			if (pixel_queue.size() == 0) begin
				$error("unexpected pixel %p", pix.data);
				fails++;
			end else begin
				want = pixel_queue.pop_front();
				if (pix.data.pixel_valid !== want.pixel_valid) begin
					$error("pixel_valid exp %0d got %0d", want.pixel_valid, pix.data.pixel_valid);
					fails++;
				end
				if (pix.data.pixel_x !== want.pixel_x) begin
					$error("pixel_x exp %0d got %0d", want.pixel_x, pix.data.pixel_x);
					fails++;
				end
				if (pix.data.pixel_y !== want.pixel_y) begin
					$error("pixel_y exp %0d got %0d", want.pixel_y, pix.data.pixel_y);
					fails++;
				end
				if (pix.data.pixel_paint !== want.pixel_paint) begin
					$error("pixel_paint exp %0h got %0h", want.pixel_paint,
						pix.data.pixel_paint);
					fails++;
				end
				if (pix.data.final_pixel !== want.final_pixel) begin
					$error("final_pixel exp %0d got %0d", want.final_pixel,
						pix.data.final_pixel);
					fails++;
				end
			end
		end
	end

	// Directed table: begins and steps; typed expectations only for trivial rows.
	typedef struct {
		ldr_pkg::req_t r;
		bit typed;
		ldr_pkg::pix_t want;
	} row_t;
	row_t directed[$];

	task automatic add_row(ldr_pkg::req_t r, bit typed = 1'b0, ldr_pkg::pix_t want = '0);
		row_t w;
		w.r = r; w.typed = typed; w.want = want;
		directed.push_back(w);
	endtask

	// Watchdog.
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int count, got, phase;
		ldr_pkg::pix_t exp_idle;
		req.valid = 1'b0;
		req.data = '0;
		pix.ready = 1'b0;
		walk = WALK_IDLE;
		{cur_x, cur_y, end_x, end_y, ctr_x, ctr_y, rad, span_x, span_y} = '0;
		held_paint = '0; err = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		exp_idle = '0;
		// step while idle gives all zeros
		add_row(make_req(ldr_pkg::CMD_STEP, 4095, 4095, 4095, 4095, 255, 16'hFFFF), 1'b1,
			exp_idle);
		add_row(make_req(ldr_pkg::CMD_NONE, 4095, 4095, 4095, 4095, 255, 16'hFFFF));
		// zero-length line at the far corner: one final pixel
		add_row(make_req(ldr_pkg::CMD_LINE, 4095, 4095, 4095, 4095, 0, 16'hFFFF));
		add_row(make_req(ldr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0), 1'b1,
			ldr_pkg::pix_t'({1'b1, 12'd4095, 12'd4095, 16'hFFFF, 1'b1}));
		// swapped endpoints, steep and tie cases
		add_row(make_req(ldr_pkg::CMD_LINE, 3, 0, 0, 3, 0, 16'h1234));
		repeat (4) add_row(make_req(ldr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));
		add_row(make_req(ldr_pkg::CMD_LINE, 5, 0, 5, 3, 0, 16'h0001));
		repeat (2) add_row(make_req(ldr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));
		// begin while busy drops the line; disc at the origin clips off canvas
		add_row(make_req(ldr_pkg::CMD_DISC, 0, 0, 0, 0, 1, 16'h8000));
		repeat (9) add_row(make_req(ldr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0));
		// zero-radius disc
		add_row(make_req(ldr_pkg::CMD_DISC, 4095, 0, 0, 0, 0, 16'hABCD));
		add_row(make_req(ldr_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0), 1'b1,
			ldr_pkg::pix_t'({1'b1, 12'd4095, 12'd0, 16'hABCD, 1'b1}));

		foreach (directed[i]) begin
			send_request(directed[i].r);
			if (directed[i].typed && pixel_queue.size() != 0)
				pixel_queue[$] = directed[i].want;
		end
		wait_drain();

		// random phases with different idling
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 76 : 0;
			recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 23 : 0;
			count = 0;
			while (count < 200) begin
				random_primitive(got);
				count += got;
			end
			// pause the sender until everything has come back
			wait_drain();
		end

		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_recv = 1'b1;
				repeat (60) @(negedge clk);
				hold_recv = 1'b0;
			end
			begin
				send_request(make_req(ldr_pkg::CMD_DISC, 100, 100, 0, 0, 3, 16'h5A5A));
				step_n(20);
			end
		join
		wait_drain();
		repeat (10) @(posedge clk);

		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
